@@ src/mls_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the multiphase load stepper.
package mls_pkg;

    // Item operation codes
    typedef enum logic [2:0] {
        OP_QUERY_DOWN = 3'd0,
        OP_QUERY_UP   = 3'd1,
        OP_APPLY_KEEP = 3'd2,
        OP_APPLY_DOWN = 3'd3,
        OP_APPLY_UP   = 3'd4
    } t_op;

    // Configuration register indexes (byte address is four times the index)
    localparam logic [2:0] REG_THR1    = 3'd0;
    localparam logic [2:0] REG_THR2    = 3'd1;
    localparam logic [2:0] REG_THR3    = 3'd2;
    localparam logic [2:0] REG_HYS1    = 3'd3;
    localparam logic [2:0] REG_HYS2    = 3'd4;
    localparam logic [2:0] REG_HYS3    = 3'd5;
    localparam logic [2:0] REG_LOCKOUT = 3'd6;

    localparam int          MAX_PHASES    = 3;
    localparam int          CFG_W         = 16;
    localparam int          TS_W          = 32;
    localparam int          ENERGY_W      = 48;
    localparam int          RUN_W         = 50;
    localparam int          KWMIN_W       = 33;
    localparam int          DAY_W         = 16;
    localparam logic [15:0] LOCKOUT_RESET = 16'd1800;
    localparam logic [47:0] ENERGY_MAX    = 48'hFFFF_FFFF_FFFF;

    // Day number: 86400 = 128 * 675, so shift by seven, then multiply by a
    // rounded-up reciprocal of 675 that is exact for 25-bit numerators
    localparam longint unsigned SECONDS_PER_DAY = 64'd86400;
    localparam int              DAY_SHIFT       = 7;
    localparam int              DAY_NUM_W       = TS_W - DAY_SHIFT;
    localparam longint unsigned DAY_DIV         = SECONDS_PER_DAY >> DAY_SHIFT;
    localparam int              DAY_RSH         = 35;
    localparam int              DAY_RECIP_W     = 26;
    localparam logic [DAY_RECIP_W-1:0] DAY_RECIP =
        DAY_RECIP_W'(((64'd1 << DAY_RSH) + DAY_DIV - 64'd1) / DAY_DIV);
    localparam int              DAY_PROD_W      = DAY_NUM_W + DAY_RECIP_W;

    // kW*min: 60000 = 32 * 1875, shift by five, then an exact reciprocal of
    // 1875 for 43-bit numerators, applied as four 22-bit partial products
    localparam longint unsigned WS_PER_KWMIN = 64'd60000;
    localparam int              KWMIN_SHIFT  = 5;
    localparam longint unsigned KWMIN_DIV    = WS_PER_KWMIN >> KWMIN_SHIFT;
    localparam int              KWMIN_NUM_W  = ENERGY_W - KWMIN_SHIFT;
    localparam int              KWMIN_RSH    = 54;
    localparam int              KWMIN_RECIP_W = 44;
    localparam logic [KWMIN_RECIP_W-1:0] KWMIN_RECIP =
        KWMIN_RECIP_W'(((64'd1 << KWMIN_RSH) + KWMIN_DIV - 64'd1) / KWMIN_DIV);
    localparam int              SPLIT        = 22;

    // Per-item result bits that travel down the energy pipeline
    typedef struct packed {
        logic       decision;
        logic [2:0] selector;
        logic [1:0] allowed;
        logic       apply;
    } t_res;

endpackage

@@ src/multiphase_load_stepper.sv @@
`timescale 1ns / 1ps
// Relay phase stepper for a surplus-power load: control stage, energy pipeline, config port.
//
// The block takes one item per clock while o_stall is low and returns one result per item,
// in order. The phase selector, rotation indexes, allowed phase count and lockout timestamp
// are updated from the input register, so queries and applies can follow each other back to
// back. Today's energy and the kW*min figure then run through six register stages: the
// control result, on-time products (three parallel 32x16 multipliers and the day-number
// reciprocal), the saturating daily accumulator, the total, four 22-bit partial products of
// the divide by 60000, and the final sum. Every stage holds its beat only while the stage
// behind it is full and stalled, so input beats are still taken while a result waits at the
// output if any stage is empty. Configuration is an APB-style slave with zero wait states;
// the user must write thresholds, hysteresis and lockout only while idle (unenforced).
module multiphase_load_stepper #(
    parameter int unsigned PHASES = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [2:0]                   i_op,
    input  logic [mls_pkg::TS_W-1:0]     i_timestamp,
    input  logic signed [31:0]           i_grid_power,
    input  logic [2:0]                   i_enable_bits,
    input  logic [2:0]                   i_reported_states,
    input  logic                         i_feedback_valid,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_decision,
    output logic [2:0]                   o_selector_state,
    output logic [mls_pkg::KWMIN_W-1:0]  o_energy_kwmin,
    output logic [1:0]                   o_allowed_phases,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import mls_pkg::*;

    localparam int          STAGES    = 7;
    localparam logic [1:0]  LAST_IDX  = 2'(PHASES - 1);
    localparam logic [1:0]  ALL_PHASE = 2'(PHASES);
    localparam int          ACC_W     = KWMIN_NUM_W + KWMIN_RECIP_W;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] r_thr [MAX_PHASES];
    logic [CFG_W-1:0] r_hys [MAX_PHASES];
    logic [CFG_W-1:0] r_lock;

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PHASES; i++) begin
                r_thr[i] <= '0;
                r_hys[i] <= '0;
            end
            r_lock <= LOCKOUT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_THR1:    r_thr[0] <= pwdata[CFG_W-1:0];
                REG_THR2:    r_thr[1] <= pwdata[CFG_W-1:0];
                REG_THR3:    r_thr[2] <= pwdata[CFG_W-1:0];
                REG_HYS1:    r_hys[0] <= pwdata[CFG_W-1:0];
                REG_HYS2:    r_hys[1] <= pwdata[CFG_W-1:0];
                REG_HYS3:    r_hys[2] <= pwdata[CFG_W-1:0];
                REG_LOCKOUT: r_lock   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_THR1:    prdata = {16'd0, r_thr[0]};
            REG_THR2:    prdata = {16'd0, r_thr[1]};
            REG_THR3:    prdata = {16'd0, r_thr[2]};
            REG_HYS1:    prdata = {16'd0, r_hys[0]};
            REG_HYS2:    prdata = {16'd0, r_hys[1]};
            REG_HYS3:    prdata = {16'd0, r_hys[2]};
            REG_LOCKOUT: prdata = {16'd0, r_lock};
            default:     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------- pipeline flow ----------------
    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] rdy;

    // A stage loads when it is empty or the stage behind it moves
    always_comb begin
        rdy[STAGES-1] = !r_v[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[0];
    assign o_valid = r_v[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: input register ----------------
    logic [2:0]             r_s0_op;
    logic [TS_W-1:0]        r_s0_ts;
    logic signed [31:0]     r_s0_grid;
    logic [2:0]             r_s0_en;
    logic [2:0]             r_s0_rep;
    logic                   r_s0_fbv;

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s0_op   <= i_op;
            r_s0_ts   <= i_timestamp;
            r_s0_grid <= i_grid_power;
            r_s0_en   <= i_enable_bits;
            r_s0_rep  <= i_reported_states;
            r_s0_fbv  <= i_feedback_valid;
        end
    end

    // ---------------- control state ----------------
    logic                   r_phase_on [PHASES];
    logic [TS_W-1:0]        r_on_time  [PHASES];
    logic [1:0]             r_down_idx;
    logic [1:0]             r_up_idx;
    logic [1:0]             r_allowed;
    logic [TS_W-1:0]        r_last_dec;

    logic                   n_phase_on [PHASES];
    logic [TS_W-1:0]        n_on_time  [PHASES];
    logic [1:0]             n_down_idx;
    logic [1:0]             n_up_idx;
    logic [1:0]             n_allowed;
    logic [TS_W-1:0]        n_last_dec;

    t_op                    op;
    logic [1:0]             down_idx;
    logic [1:0]             up_idx;
    logic signed [TS_W:0]   since_dec;
    logic                   lock_in;
    logic [1:0]             rep_count;
    logic signed [33:0]     margin;
    t_res                   ctl_res;
    logic [TS_W-1:0]        ctl_dt   [PHASES];
    logic [PHASES-1:0]      ctl_run;
    logic [PHASES-1:0]      ctl_add;

    // Decide the query answer and the next selector, index and count values
    always_comb begin
        op        = t_op'(r_s0_op);
        down_idx  = r_down_idx;
        up_idx    = r_up_idx;
        since_dec = $signed({1'b0, r_s0_ts}) - $signed({1'b0, r_last_dec});
        lock_in   = since_dec < $signed({17'd0, r_lock});
        rep_count = '0;
        for (int i = 0; i < PHASES; i++) begin
            rep_count = rep_count + 2'(r_s0_rep[i]);
        end
        // negative when export beats threshold plus hysteresis of the next phase up
        margin = $signed({{2{r_s0_grid[31]}}, r_s0_grid})
               + $signed({18'd0, r_thr[up_idx]})
               + $signed({18'd0, r_hys[up_idx]});

        for (int i = 0; i < PHASES; i++) begin
            n_phase_on[i] = r_phase_on[i];
            n_on_time[i]  = r_on_time[i];
        end
        n_down_idx = r_down_idx;
        n_up_idx   = r_up_idx;
        n_allowed  = r_allowed;
        n_last_dec = r_last_dec;
        ctl_res    = '0;

        case (op)
            OP_QUERY_DOWN: begin
                if (r_s0_fbv && r_s0_rep[down_idx]) begin
                    if (!r_s0_en[down_idx]) begin
                        // enable input lost: lower the allowed count outside the lockout
                        if (r_allowed != 2'd0 && !lock_in) begin
                            n_last_dec = r_s0_ts;
                            n_allowed  = r_allowed - 2'd1;
                        end
                        ctl_res.decision = 1'b1;
                    end else if (r_s0_grid > 32'sd0) begin
                        ctl_res.decision = 1'b1;
                    end
                end
            end
            OP_QUERY_UP: begin
                if (r_s0_fbv && !r_s0_rep[up_idx] && r_s0_en[up_idx]) begin
                    if (r_allowed < ALL_PHASE && !lock_in) begin
                        n_allowed = r_allowed + 2'd1;
                    end
                    if (rep_count < n_allowed && margin < 34'sd0) begin
                        ctl_res.decision = 1'b1;
                    end
                end
            end
            OP_APPLY_KEEP: begin
                ctl_res.apply = 1'b1;
            end
            OP_APPLY_DOWN: begin
                ctl_res.apply        = 1'b1;
                n_phase_on[down_idx] = 1'b0;
                n_down_idx = (down_idx == LAST_IDX) ? 2'd0 : down_idx + 2'd1;
            end
            OP_APPLY_UP: begin
                ctl_res.apply      = 1'b1;
                n_on_time[up_idx]  = r_s0_ts;
                n_phase_on[up_idx] = 1'b1;
                n_up_idx = (up_idx == LAST_IDX) ? 2'd0 : up_idx + 2'd1;
            end
            default: ;
        endcase

        ctl_res.allowed = n_allowed;
        // Elapsed on-time per phase, zero when the clock runs backwards
        for (int i = 0; i < PHASES; i++) begin
            ctl_res.selector[i] = n_phase_on[i];
            ctl_dt[i]  = (r_s0_ts >= n_on_time[i]) ? r_s0_ts - n_on_time[i] : '0;
            ctl_run[i] = n_phase_on[i];
            ctl_add[i] = (op == OP_APPLY_DOWN) && (down_idx == 2'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PHASES; i++) begin
                r_phase_on[i] <= 1'b0;
                r_on_time[i]  <= '0;
            end
            r_down_idx <= '0;
            r_up_idx   <= '0;
            r_allowed  <= ALL_PHASE;
            r_last_dec <= '0;
        end else if (r_v[0] && rdy[1]) begin
            for (int i = 0; i < PHASES; i++) begin
                r_phase_on[i] <= n_phase_on[i];
                r_on_time[i]  <= n_on_time[i];
            end
            r_down_idx <= n_down_idx;
            r_up_idx   <= n_up_idx;
            r_allowed  <= n_allowed;
            r_last_dec <= n_last_dec;
        end
    end

    // ---------------- stage 1: control result ----------------
    t_res                   r_s1_res;
    logic [PHASES-1:0]      r_s1_run;
    logic [PHASES-1:0]      r_s1_add;
    logic [DAY_NUM_W-1:0]   r_s1_tsd;
    logic [TS_W-1:0]        r_s1_dt [PHASES];

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s1_res <= ctl_res;
            r_s1_run <= ctl_run;
            r_s1_add <= ctl_add;
            r_s1_tsd <= r_s0_ts[TS_W-1:DAY_SHIFT];
            for (int i = 0; i < PHASES; i++) begin
                r_s1_dt[i] <= ctl_dt[i];
            end
        end
    end

    // ---------------- stage 2: products ----------------
    t_res                   r_s2_res;
    logic [PHASES-1:0]      r_s2_run;
    logic [PHASES-1:0]      r_s2_add;
    logic [DAY_PROD_W-1:0]  r_s2_day_prod;
    logic [ENERGY_W-1:0]    r_s2_pe [PHASES];

    // Watt-seconds per phase and the scaled day number
    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_s2_res      <= r_s1_res;
            r_s2_run      <= r_s1_run;
            r_s2_add      <= r_s1_add;
            r_s2_day_prod <= {{DAY_RECIP_W{1'b0}}, r_s1_tsd}
                           * {{DAY_NUM_W{1'b0}}, DAY_RECIP};
            for (int i = 0; i < PHASES; i++) begin
                r_s2_pe[i] <= {16'd0, r_s1_dt[i]} * {32'd0, r_thr[i]};
            end
        end
    end

    // ---------------- stage 3: daily accumulator ----------------
    logic [DAY_W-1:0]       r_current_day;
    logic [ENERGY_W-1:0]    r_energy_today;
    t_res                   r_s3_res;
    logic [RUN_W-1:0]       r_s3_running;

    logic [DAY_W-1:0]       day;
    logic [ENERGY_W-1:0]    base;
    logic [ENERGY_W-1:0]    pe_add;
    logic [ENERGY_W:0]      today_sum;
    logic [ENERGY_W-1:0]    today_next;
    logic [RUN_W-1:0]       running;

    // Clear on a new day, add the switched-off phase, sum the phases still on
    always_comb begin
        day     = r_s2_day_prod[DAY_PROD_W-1:DAY_RSH];
        pe_add  = '0;
        running = '0;
        for (int i = 0; i < PHASES; i++) begin
            if (r_s2_add[i]) begin
                pe_add = pe_add | r_s2_pe[i];
            end
            if (r_s2_run[i]) begin
                running = running + RUN_W'(r_s2_pe[i]);
            end
        end
        base       = (day != r_current_day) ? '0 : r_energy_today;
        today_sum  = {1'b0, base} + {1'b0, pe_add};
        today_next = today_sum[ENERGY_W] ? ENERGY_MAX : today_sum[ENERGY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_day  <= '0;
            r_energy_today <= '0;
        end else if (r_v[2] && rdy[3] && r_s2_res.apply) begin
            r_current_day  <= day;
            r_energy_today <= today_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_s3_res     <= r_s2_res;
            r_s3_running <= running;
        end
    end

    // ---------------- stage 4: today's total ----------------
    // The accumulator holds the value left by the last apply beat that reached stage 3
    t_res                   r_s4_res;
    logic [KWMIN_NUM_W-1:0] r_s4_x;
    logic [RUN_W:0]         total_sum;
    logic [ENERGY_W-1:0]    total;

    always_comb begin
        total_sum = {3'd0, r_energy_today} + {1'b0, r_s3_running};
        total     = (total_sum > {3'd0, ENERGY_MAX}) ? ENERGY_MAX
                                                     : total_sum[ENERGY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_s4_res <= r_s3_res;
            r_s4_x   <= total[ENERGY_W-1:KWMIN_SHIFT];
        end
    end

    // ---------------- stage 5: partial products ----------------
    t_res                   r_s5_res;
    logic [42:0]            r_s5_hh;
    logic [42:0]            r_s5_hl;
    logic [43:0]            r_s5_lh;
    logic [43:0]            r_s5_ll;

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_s5_res <= r_s4_res;
            r_s5_hh  <= {22'd0, r_s4_x[KWMIN_NUM_W-1:SPLIT]}
                      * {21'd0, KWMIN_RECIP[KWMIN_RECIP_W-1:SPLIT]};
            r_s5_hl  <= {22'd0, r_s4_x[KWMIN_NUM_W-1:SPLIT]}
                      * {21'd0, KWMIN_RECIP[SPLIT-1:0]};
            r_s5_lh  <= {22'd0, r_s4_x[SPLIT-1:0]}
                      * {22'd0, KWMIN_RECIP[KWMIN_RECIP_W-1:SPLIT]};
            r_s5_ll  <= {22'd0, r_s4_x[SPLIT-1:0]}
                      * {22'd0, KWMIN_RECIP[SPLIT-1:0]};
        end
    end

    // ---------------- stage 6: quotient and output register ----------------
    t_res                   r_s6_res;
    logic [KWMIN_W-1:0]     r_s6_energy;
    logic [44:0]            mid;
    logic [ACC_W-1:0]       acc;

    always_comb begin
        mid = {2'd0, r_s5_hl} + {1'b0, r_s5_lh};
        acc = {r_s5_hh, 44'd0}
            + {20'd0, mid, 22'd0}
            + {43'd0, r_s5_ll};
    end

    // Energy is reported on apply beats only
    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r_s6_res    <= r_s5_res;
            r_s6_energy <= r_s5_res.apply ? acc[ACC_W-1:KWMIN_RSH] : '0;
        end
    end

    assign o_decision       = r_s6_res.decision;
    assign o_selector_state = r_s6_res.selector;
    assign o_allowed_phases = r_s6_res.allowed;
    assign o_energy_kwmin   = r_s6_energy;

endmodule

@@ test/tb_multiphase_load_stepper.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the multiphase load stepper: directed table, random beats, APB set-up.
module tb_multiphase_load_stepper;
    import mls_pkg::*;

    localparam int         RESET_CYCLES    = 4;
    localparam int         DRAIN_CYCLES    = 12;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         ITEMS_PER_PHASE = 125;
    localparam int         DIR_COUNT       = 27;
    localparam logic [2:0] OP_RESERVED_LO  = 3'd5;
    localparam logic [2:0] OP_RESERVED_HI  = 3'd7;

    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        ts;
        logic signed [31:0] grid;
        logic [2:0]         en;
        logic [2:0]         rep;
        logic               fb_ok;
    } t_item;

    typedef struct packed {
        logic               decision;
        logic [2:0]         selector;
        logic [KWMIN_W-1:0] kwmin;
        logic [1:0]         allowed;
    } t_result;

    // rewrite: drain and load the extreme register set before this row
    typedef struct packed {
        logic    rewrite;
        t_item   it;
        logic    typed;
        t_result want;
    } t_row;

    localparam t_result NO_RES = '0;

    localparam t_row DIR_ROWS [DIR_COUNT] = '{
        // invalid feedback, then a keep straight after reset
        '{1'b0, '{OP_QUERY_DOWN, 32'd0, 32'sd1, 3'd0, 3'd7, 1'b0}, 1'b1, '{1'b0, 3'd0, 33'd0, 2'd3}},
        '{1'b0, '{OP_APPLY_KEEP, 32'd0, 32'sd0, 3'd7, 3'd0, 1'b1}, 1'b1, '{1'b0, 3'd0, 33'd0, 2'd3}},
        // enable dropped inside lockout, outside it, and with time running backwards
        '{1'b0, '{OP_QUERY_DOWN, 32'd1000, 32'sd0, 3'd0, 3'd1, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_QUERY_DOWN, 32'd5000, 32'sd0, 3'd6, 3'd7, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_QUERY_DOWN, 32'd4000, 32'sd0, 3'd0, 3'd1, 1'b1}, 1'b0, NO_RES},
        // up inside lockout, then after it with grid at zero
        '{1'b0, '{OP_QUERY_UP, 32'd6000, -32'sd1, 3'd1, 3'd0, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_QUERY_UP, 32'd7000, 32'sd0, 3'd1, 3'd0, 1'b1}, 1'b0, NO_RES},
        // grid extremes
        '{1'b0, '{OP_QUERY_DOWN, 32'd7000, 32'sh7FFF_FFFF, 3'd7, 3'd1, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_QUERY_UP, 32'd7000, 32'sh8000_0000, 3'd1, 3'd6, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_RESERVED_HI, 32'd7000, 32'sh8000_0000, 3'd7, 3'd7, 1'b1},
          1'b1, '{1'b0, 3'd0, 33'd0, 2'd3}},
        // zero lockout: count down to its floor and back up to its ceiling
        '{1'b1, '{OP_QUERY_DOWN, 32'd10000, 32'sd0, 3'd0, 3'd7, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_QUERY_DOWN, 32'd10000, 32'sd0, 3'd0, 3'd7, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_QUERY_DOWN, 32'd10000, 32'sd0, 3'd0, 3'd7, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_QUERY_DOWN, 32'd10000, 32'sd0, 3'd0, 3'd7, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_QUERY_UP, 32'd10000, -32'sd131071, 3'd7, 3'd0, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_QUERY_UP, 32'd10000, -32'sd131070, 3'd7, 3'd0, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_QUERY_UP, 32'd10000, -32'sd131071, 3'd7, 3'd0, 1'b1}, 1'b0, NO_RES},
        // all phases on at time zero, then saturate the energy at the last second
        '{1'b0, '{OP_APPLY_UP, 32'd0, 32'sd0, 3'd7, 3'd7, 1'b1}, 1'b1, '{1'b0, 3'd1, 33'd0, 2'd3}},
        '{1'b0, '{OP_APPLY_UP, 32'd0, 32'sd0, 3'd7, 3'd7, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_APPLY_UP, 32'd0, 32'sd0, 3'd0, 3'd0, 1'b0}, 1'b0, NO_RES},
        '{1'b0, '{OP_APPLY_KEEP, 32'hFFFF_FFFF, 32'sd0, 3'd7, 3'd7, 1'b1},
          1'b1, '{1'b0, 3'd7, 33'd4691249611, 2'd3}},
        '{1'b0, '{OP_APPLY_DOWN, 32'hFFFF_FFFF, 32'sd0, 3'd7, 3'd7, 1'b1},
          1'b1, '{1'b0, 3'd6, 33'd4691249611, 2'd3}},
        // new day, then down on a phase already off
        '{1'b0, '{OP_APPLY_DOWN, 32'd0, 32'sd0, 3'd7, 3'd7, 1'b1}, 1'b1, '{1'b0, 3'd4, 33'd0, 2'd3}},
        '{1'b0, '{OP_APPLY_DOWN, 32'd0, 32'sd0, 3'd7, 3'd7, 1'b1}, 1'b0, NO_RES},
        '{1'b0, '{OP_APPLY_DOWN, 32'd60000, 32'sd0, 3'd7, 3'd7, 1'b1},
          1'b1, '{1'b0, 3'd0, 33'd65535, 2'd3}},
        // timestamp before the on-time counts as no time
        '{1'b0, '{OP_APPLY_UP, 32'd80000, 32'sd0, 3'd7, 3'd7, 1'b1},
          1'b1, '{1'b0, 3'd1, 33'd65535, 2'd3}},
        '{1'b0, '{OP_APPLY_KEEP, 32'd70000, 32'sd0, 3'd7, 3'd7, 1'b1},
          1'b1, '{1'b0, 3'd1, 33'd65535, 2'd3}}
    };

    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_valid           = 1'b0;
    logic               o_stall;
    logic [2:0]         i_op              = '0;
    logic [TS_W-1:0]    i_timestamp       = '0;
    logic signed [31:0] i_grid_power      = '0;
    logic [2:0]         i_enable_bits     = '0;
    logic [2:0]         i_reported_states = '0;
    logic               i_feedback_valid  = 1'b0;
    logic               o_valid;
    logic               i_stall           = 1'b0;
    logic               o_decision;
    logic [2:0]         o_selector_state;
    logic [KWMIN_W-1:0] o_energy_kwmin;
    logic [1:0]         o_allowed_phases;
    logic               psel              = 1'b0;
    logic               penable           = 1'b0;
    logic               pwrite            = 1'b0;
    logic [4:0]         paddr             = '0;
    logic [31:0]        pwdata            = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Register copies and stepper state as they stand after reset
    bit [15:0]       cfg_threshold [3] = '{16'd0, 16'd0, 16'd0};
    bit [15:0]       cfg_hysteresis [3] = '{16'd0, 16'd0, 16'd0};
    bit [15:0]       cfg_lockout    = LOCKOUT_RESET;
    bit [2:0]        relay_on       = '0;
    bit [31:0]       relay_on_ts [3] = '{32'd0, 32'd0, 32'd0};
    bit [1:0]        down_slot      = '0;
    bit [1:0]        up_slot        = '0;
    bit [1:0]        phase_budget   = 2'(MAX_PHASES);
    bit [31:0]       last_drop_ts   = '0;
    int unsigned     day_number     = 0;
    longint unsigned energy_ws      = 0;

    t_result     pending_results [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit [31:0]   ts_clock       = '0;

    multiphase_load_stepper dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit lockout_active(bit [31:0] ts);
        longint delta;
        delta = longint'(ts) - longint'(last_drop_ts);
        return delta < longint'(cfg_lockout);
    endfunction

    function automatic longint unsigned phase_ws(int slot, bit [31:0] ts);
        longint unsigned dt;
        dt = (ts >= relay_on_ts[slot]) ? longint'(ts - relay_on_ts[slot]) : 0;
        return dt * cfg_threshold[slot];
    endfunction

    function automatic longint unsigned clamp_ws(longint unsigned s);
        return (s > 64'(ENERGY_MAX)) ? 64'(ENERGY_MAX) : s;
    endfunction

    // Advance the stepper state by one beat and return the result it should give
    function automatic t_result advance_relay_model(t_item it);
        t_result         r;
        longint          grid;
        longint unsigned running;
        int unsigned     day;
        r       = '0;
        grid    = it.grid;
        running = 0;
        case (it.op)
            OP_QUERY_DOWN: begin
                if (it.fb_ok && it.rep[down_slot]) begin
                    if (!it.en[down_slot]) begin
                        if (phase_budget != 0 && !lockout_active(it.ts)) begin
                            last_drop_ts = it.ts;
                            phase_budget = phase_budget - 2'd1;
                        end
                        r.decision = 1'b1;
                    end else if (grid > 0) begin
                        r.decision = 1'b1;
                    end
                end
            end
            OP_QUERY_UP: begin
                if (it.fb_ok && !it.rep[up_slot] && it.en[up_slot]) begin
                    if (phase_budget < MAX_PHASES && !lockout_active(it.ts))
                        phase_budget = phase_budget + 2'd1;
                    if ($countones(it.rep) < phase_budget &&
                        grid < -longint'(cfg_threshold[up_slot]) - longint'(cfg_hysteresis[up_slot]))
                        r.decision = 1'b1;
                end
            end
            OP_APPLY_KEEP, OP_APPLY_DOWN, OP_APPLY_UP: begin
                day = int'(it.ts / SECONDS_PER_DAY);
                if (day != day_number) begin
                    day_number = day;
                    energy_ws  = 0;
                end
                if (it.op == OP_APPLY_DOWN) begin
                    energy_ws           = clamp_ws(energy_ws + phase_ws(down_slot, it.ts));
                    relay_on[down_slot] = 1'b0;
                    down_slot           = (down_slot == 2'd2) ? 2'd0 : down_slot + 2'd1;
                end else if (it.op == OP_APPLY_UP) begin
                    relay_on_ts[up_slot] = it.ts;
                    relay_on[up_slot]    = 1'b1;
                    up_slot              = (up_slot == 2'd2) ? 2'd0 : up_slot + 2'd1;
                end
                for (int i = 0; i < MAX_PHASES; i++)
                    if (relay_on[i])
                        running += phase_ws(i, it.ts);
                r.kwmin = KWMIN_W'(clamp_ws(energy_ws + running) / WS_PER_KWMIN);
            end
            default: ;
        endcase
        r.selector = relay_on;
        r.allowed  = phase_budget;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Random beat: mostly a device that reports what was switched, with time moving forward
    function automatic t_item random_item();
        t_item       it;
        int unsigned pick;
        longint      g;
        pick = $urandom_range(0, 99);
        if (pick < 20)      it.op = OP_QUERY_DOWN;
        else if (pick < 40) it.op = OP_QUERY_UP;
        else if (pick < 55) it.op = OP_APPLY_KEEP;
        else if (pick < 75) it.op = OP_APPLY_DOWN;
        else if (pick < 96) it.op = OP_APPLY_UP;
        else                it.op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
        pick = $urandom_range(0, 99);
        if (pick < 70)      ts_clock = ts_clock + $urandom_range(0, 1500);
        else if (pick < 85) ts_clock = ts_clock + $urandom_range(80000, 200000);
        else if (pick < 93) ts_clock = ts_clock - $urandom_range(0, 3000);
        else                ts_clock = $urandom;
        it.ts = ts_clock;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            g = longint'($urandom_range(0, 4000)) - 2000
                - longint'(cfg_threshold[up_slot]) - longint'(cfg_hysteresis[up_slot]);
            it.grid = g[31:0];
        end else if (pick < 80) begin
            it.grid = $signed($urandom_range(0, 6000)) - 3000;
        end else begin
            it.grid = $urandom;
        end
        it.en    = ($urandom_range(0, 99) < 75) ? 3'd7 : 3'($urandom_range(0, 7));
        it.rep   = ($urandom_range(0, 99) < 80) ? relay_on : 3'($urandom_range(0, 7));
        it.fb_ok = ($urandom_range(0, 9) != 0);
        return it;
    endfunction

    // Offer one beat after a random gap, hold it until taken, then log its result
    task automatic send_item(input t_item it, input bit typed, input t_result want);
        t_result model_out;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_op              <= it.op;
        i_timestamp       <= it.ts;
        i_grid_power      <= it.grid;
        i_enable_bits     <= it.en;
        i_reported_states <= it.rep;
        i_feedback_valid  <= it.fb_ok;
        i_valid           <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        model_out = advance_relay_model(it);
        pending_results.push_back(typed ? want : model_out);
    endtask

    // Drop valid and wait until every logged result has come back
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup, then access; psel is left high for a following transfer
    task automatic apb_cycle(input bit wr, input logic [2:0] idx, input bit [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (!wr && prdata !== {16'd0, val}) begin
            $display("%0t: register %0d expected %0d, got %0d", $time, idx, val, prdata);
            mismatch_count++;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input bit [15:0] val);
        apb_cycle(1'b1, idx, val);
        case (idx)
            REG_THR1:    cfg_threshold[0]  = val;
            REG_THR2:    cfg_threshold[1]  = val;
            REG_THR3:    cfg_threshold[2]  = val;
            REG_HYS1:    cfg_hysteresis[0] = val;
            REG_HYS2:    cfg_hysteresis[1] = val;
            REG_HYS3:    cfg_hysteresis[2] = val;
            REG_LOCKOUT: cfg_lockout       = val;
            default: ;
        endcase
        apb_cycle(1'b0, idx, val);
    endtask

    task automatic program_registers(input bit [15:0] t1, t2, t3, h1, h2, h3, lock);
        write_reg(REG_THR1, t1);
        write_reg(REG_THR2, t2);
        write_reg(REG_THR3, t3);
        write_reg(REG_HYS1, h1);
        write_reg(REG_HYS2, h2);
        write_reg(REG_HYS3, h3);
        write_reg(REG_LOCKOUT, lock);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver back-pressure
    always @(posedge i_clk)
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat expected none, got selector %0d energy %0d",
                         $time, o_selector_state, o_energy_kwmin);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("decision", 64'(want.decision), 64'(o_decision));
                check_field("selector_state", 64'(want.selector), 64'(o_selector_state));
                check_field("energy_kwmin", 64'(want.kwmin), 64'(o_energy_kwmin));
                check_field("allowed_phases", 64'(want.allowed), 64'(o_allowed_phases));
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_multiphase_load_stepper NOT OK");
            $finish;
        end
    end

    initial begin
        t_item it;
        int    kept;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int k = 0; k < DIR_COUNT; k++) begin
            if (DIR_ROWS[k].rewrite) begin
                settle();
                program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
            end
            send_item(DIR_ROWS[k].it, DIR_ROWS[k].typed, DIR_ROWS[k].want);
        end

        // Random beats under four register sets and idling patterns
        for (int p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: begin
                    program_registers(16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 3000)),
                                      16'($urandom_range(0, 3000)),
                                      16'($urandom_range(0, 3000)), 16'd0);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      16'd0, 16'd0, 16'd0, 16'hFFFF);
                    send_idle_pct  = 56;
                    recv_stall_pct = 0;
                end
                2: begin
                    program_registers(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      16'($urandom_range(0, 3000)));
                    send_idle_pct  = 0;
                    recv_stall_pct = 56;
                end
                default: begin
                    program_registers(16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)));
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            kept = 0;
            while (kept < ITEMS_PER_PHASE) begin
                it = random_item();
                send_item(it, 1'b0, NO_RES);
                if (it.op <= OP_APPLY_UP)
                    kept++;
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("tb_multiphase_load_stepper OK");
        else
            $display("tb_multiphase_load_stepper NOT OK");
        $finish;
    end

endmodule
